### rtl/crfdt_pkg.sv
// shared types and constants for the clipped rectangle fill / dirty tracker
// no dependencies; used by the controller, datapath and top level
package crfdt_pkg;

  // command mode codes
  localparam logic [2:0] MODE_PIXEL = 3'd0;
  localparam logic [2:0] MODE_RECT  = 3'd1;
  localparam logic [2:0] MODE_FILL  = 3'd2;
  localparam logic [2:0] MODE_FLUSH = 3'd3;
  localparam logic [2:0] MODE_READ  = 3'd4;

  // what the captured command turned into after clipping
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_WRITE,
    KIND_READ,
    KIND_FLUSH
  } kind_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLR_INIT,
    ST_CLR_SETUP,
    ST_CLR_FILL,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic load_clear;
    logic setup;
    logic step;
    logic result_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  last;
  } dp_status_t;

endpackage

### rtl/crfdt_cmd_if.sv
// command channel: valid/ready handshake with the drawing command payload
// depends on nothing
interface crfdt_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] rect_width;
  logic signed [15:0] rect_height;
  logic [15:0]        color;

  modport source (output valid, mode, pos_x, pos_y, rect_width, rect_height, color,
                  input ready);
  modport sink   (input valid, mode, pos_x, pos_y, rect_width, rect_height, color,
                  output ready);
endinterface

// result channel: valid/ready handshake with read data and flushed region
interface crfdt_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        region_valid;
  logic [7:0]  region_x;
  logic [7:0]  region_y;
  logic [7:0]  region_width;
  logic [7:0]  region_height;

  modport source (output valid, pixel_value, region_valid, region_x, region_y,
                  region_width, region_height, input ready);
  modport sink   (input valid, pixel_value, region_valid, region_x, region_y,
                  region_width, region_height, output ready);
endinterface

### rtl/crfdt_ctrl.sv
// sequencing state machine for the framebuffer engine
// depends on crfdt_pkg; drives the datapath through dp_cmd_t
module crfdt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output crfdt_pkg::dp_cmd_t    cmd_o,
  input  crfdt_pkg::dp_status_t status_i
);

  crfdt_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crfdt_pkg::ST_CLR_INIT:  state_d = crfdt_pkg::ST_CLR_SETUP;
      crfdt_pkg::ST_CLR_SETUP: state_d = crfdt_pkg::ST_CLR_FILL;
      crfdt_pkg::ST_CLR_FILL: begin
        if (status_i.last) state_d = crfdt_pkg::ST_IDLE;
      end
      crfdt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = crfdt_pkg::ST_SETUP;
      end
      crfdt_pkg::ST_SETUP: begin
        unique case (status_i.kind)
          crfdt_pkg::KIND_WRITE: state_d = crfdt_pkg::ST_FILL;
          crfdt_pkg::KIND_READ:  state_d = crfdt_pkg::ST_READ;
          default:               state_d = crfdt_pkg::ST_DONE;
        endcase
      end
      crfdt_pkg::ST_FILL: begin
        if (status_i.last) state_d = crfdt_pkg::ST_DONE;
      end
      crfdt_pkg::ST_READ: state_d = crfdt_pkg::ST_DONE;
      crfdt_pkg::ST_DONE: begin
        if (slot_free) state_d = crfdt_pkg::ST_IDLE;
      end
      default: state_d = crfdt_pkg::ST_CLR_INIT;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      crfdt_pkg::ST_CLR_INIT:  cmd_o.load_clear = 1'b1;
      crfdt_pkg::ST_CLR_SETUP: cmd_o.setup = 1'b1;
      crfdt_pkg::ST_CLR_FILL:  cmd_o.step = 1'b1;
      crfdt_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      crfdt_pkg::ST_SETUP: cmd_o.setup = 1'b1;
      crfdt_pkg::ST_FILL:  cmd_o.step = 1'b1;
      crfdt_pkg::ST_READ:  ;
      crfdt_pkg::ST_DONE:  cmd_o.result_load = slot_free;
      default: ;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.result_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crfdt_pkg::ST_CLR_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/crfdt_datapath.sv
// clipping, pixel store, scan counters, dirty box and result register
// depends on crfdt_pkg; commanded by crfdt_ctrl
module crfdt_datapath #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crfdt_pkg::dp_cmd_t    cmd_i,
  output crfdt_pkg::dp_status_t status_o,
  input  logic [2:0]            mode_i,
  input  logic signed [15:0]    pos_x_i,
  input  logic signed [15:0]    pos_y_i,
  input  logic signed [15:0]    rect_width_i,
  input  logic signed [15:0]    rect_height_i,
  input  logic [15:0]           color_i,
  output logic [15:0]           pixel_value_o,
  output logic                  region_valid_o,
  output logic [7:0]            region_x_o,
  output logic [7:0]            region_y_o,
  output logic [7:0]            region_width_o,
  output logic [7:0]            region_height_o
);

  localparam int CWX   = $clog2(SCREEN_WIDTH);
  localparam int CWY   = $clog2(SCREEN_HEIGHT);
  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [17:0] W_S  = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H_S  = 18'(SCREEN_HEIGHT);
  localparam logic [CWX-1:0]     X_MAX = CWX'(SCREEN_WIDTH - 1);
  localparam logic [CWY-1:0]     Y_MAX = CWY'(SCREEN_HEIGHT - 1);

  // clipping of the incoming command
  logic signed [17:0] xs, ys, ws, hs, xp, yp, wp, hp, xe, ye;
  logic               x_ne, y_ne, on_scr;
  logic [CWX-1:0]     nx0, nx1;
  logic [CWY-1:0]     ny0, ny1;
  crfdt_pkg::kind_e   nkind;

  always_comb begin
    xs = 18'(pos_x_i);
    ys = 18'(pos_y_i);
    ws = 18'(rect_width_i);
    hs = 18'(rect_height_i);
    xp = (xs < 18'sd0) ? 18'sd0 : xs;
    yp = (ys < 18'sd0) ? 18'sd0 : ys;
    wp = (xs < 18'sd0) ? ws + xs : ws;
    hp = (ys < 18'sd0) ? hs + ys : hs;
    xe = xp + wp - 18'sd1;
    ye = yp + hp - 18'sd1;
    x_ne = (xp < W_S) && (wp > 18'sd0);
    y_ne = (yp < H_S) && (hp > 18'sd0);
    on_scr = (xs >= 18'sd0) && (xs < W_S) && (ys >= 18'sd0) && (ys < H_S);

    nx0   = xs[CWX-1:0];
    nx1   = xs[CWX-1:0];
    ny0   = ys[CWY-1:0];
    ny1   = ys[CWY-1:0];
    nkind = crfdt_pkg::KIND_NONE;
    unique case (mode_i)
      crfdt_pkg::MODE_PIXEL: begin
        if (on_scr) nkind = crfdt_pkg::KIND_WRITE;
      end
      crfdt_pkg::MODE_RECT: begin
        nx0 = xp[CWX-1:0];
        ny0 = yp[CWY-1:0];
        nx1 = (xe > W_S - 18'sd1) ? X_MAX : xe[CWX-1:0];
        ny1 = (ye > H_S - 18'sd1) ? Y_MAX : ye[CWY-1:0];
        if (x_ne && y_ne) nkind = crfdt_pkg::KIND_WRITE;
      end
      crfdt_pkg::MODE_FILL: begin
        nx0   = '0;
        ny0   = '0;
        nx1   = X_MAX;
        ny1   = Y_MAX;
        nkind = crfdt_pkg::KIND_WRITE;
      end
      crfdt_pkg::MODE_FLUSH: nkind = crfdt_pkg::KIND_FLUSH;
      crfdt_pkg::MODE_READ: begin
        if (on_scr) nkind = crfdt_pkg::KIND_READ;
      end
      default: nkind = crfdt_pkg::KIND_NONE;
    endcase
  end

  // captured command and scan counters
  logic [CWX-1:0]   x0_q, x1_q, col_q;
  logic [CWY-1:0]   y0_q, y1_q, row_q;
  logic [AW-1:0]    row_base_q, addr;
  logic [15:0]      color_q;
  crfdt_pkg::kind_e kind_q;
  logic             col_end, row_end;

  assign col_end = (col_q == x1_q);
  assign row_end = (row_q == y1_q);
  assign addr    = row_base_q + AW'(col_q);

  assign status_o.kind = kind_q;
  assign status_o.last = col_end && row_end;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x0_q    <= nx0;
      x1_q    <= nx1;
      y0_q    <= ny0;
      y1_q    <= ny1;
      color_q <= color_i;
      kind_q  <= nkind;
    end else if (cmd_i.load_clear) begin
      x0_q    <= '0;
      x1_q    <= X_MAX;
      y0_q    <= '0;
      y1_q    <= Y_MAX;
      color_q <= '0;
      kind_q  <= crfdt_pkg::KIND_NONE;
    end
    if (cmd_i.setup) begin
      row_base_q <= AW'(y0_q * AW'(SCREEN_WIDTH));
      col_q      <= x0_q;
      row_q      <= y0_q;
    end else if (cmd_i.step) begin
      if (col_end) begin
        col_q <= x0_q;
        if (!row_end) begin
          row_q      <= row_q + CWY'(1);
          row_base_q <= row_base_q + AW'(SCREEN_WIDTH);
        end
      end else begin
        col_q <= col_q + CWX'(1);
      end
    end
  end

  // pixel store, one write and one registered read per cycle
  logic [15:0] pixel_store_q [DEPTH];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) pixel_store_q[addr] <= color_q;
    rd_data_q <= pixel_store_q[addr];
  end

  // dirty box
  logic           dirty_q;
  logic [CWX-1:0] box_left_q, box_right_q, lx;
  logic [CWY-1:0] box_top_q, box_bottom_q;
  logic [CWX:0]   lw;
  logic [CWY:0]   lh;
  logic           do_flush;

  assign lx       = {box_left_q[CWX-1:1], 1'b0};
  assign lw       = (CWX+1)'(box_right_q) - (CWX+1)'(lx) + (CWX+1)'(1);
  assign lh       = (CWY+1)'(box_bottom_q) - (CWY+1)'(box_top_q) + (CWY+1)'(1);
  assign do_flush = (kind_q == crfdt_pkg::KIND_FLUSH) && dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q      <= 1'b0;
      box_left_q   <= '0;
      box_right_q  <= '0;
      box_top_q    <= '0;
      box_bottom_q <= '0;
    end else if (cmd_i.result_load) begin
      if (kind_q == crfdt_pkg::KIND_WRITE) begin
        dirty_q <= 1'b1;
        if (!dirty_q) begin
          box_left_q   <= x0_q;
          box_right_q  <= x1_q;
          box_top_q    <= y0_q;
          box_bottom_q <= y1_q;
        end else begin
          if (x0_q < box_left_q)   box_left_q   <= x0_q;
          if (x1_q > box_right_q)  box_right_q  <= x1_q;
          if (y0_q < box_top_q)    box_top_q    <= y0_q;
          if (y1_q > box_bottom_q) box_bottom_q <= y1_q;
        end
      end else if (do_flush) begin
        dirty_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      pixel_value_o   <= (kind_q == crfdt_pkg::KIND_READ) ? rd_data_q : 16'd0;
      region_valid_o  <= do_flush;
      region_x_o      <= do_flush ? 8'(lx) : 8'd0;
      region_y_o      <= do_flush ? 8'(box_top_q) : 8'd0;
      region_width_o  <= do_flush ? 8'(lw) : 8'd0;
      region_height_o <= do_flush ? 8'(lh) : 8'd0;
    end
  end

endmodule

### rtl/clipped_rect_fill_dirty_tracker_core.sv
// framebuffer engine: one command at a time, one pixel written per cycle.
// a clipped rectangle writes only its clipped area, a screen fill the whole store.
// the next command is taken once the previous result sits in the output register.
// after reset a clearing pass writes zero over the store, one pixel a cycle;
// no command is accepted meanwhile.
module clipped_rect_fill_dirty_tracker_core #(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  crfdt_cmd_if.sink   cmd_i,
  crfdt_res_if.source res_o
);

  crfdt_pkg::dp_cmd_t    dp_cmd;
  crfdt_pkg::dp_status_t dp_status;

  // sequencing
  crfdt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  // clipping, store and dirty box
  crfdt_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .mode_i          (cmd_i.mode),
    .pos_x_i         (cmd_i.pos_x),
    .pos_y_i         (cmd_i.pos_y),
    .rect_width_i    (cmd_i.rect_width),
    .rect_height_i   (cmd_i.rect_height),
    .color_i         (cmd_i.color),
    .pixel_value_o   (res_o.pixel_value),
    .region_valid_o  (res_o.region_valid),
    .region_x_o      (res_o.region_x),
    .region_y_o      (res_o.region_y),
    .region_width_o  (res_o.region_width),
    .region_height_o (res_o.region_height)
  );

endmodule

### test/tb_top.sv
// testbench for clipped_rect_fill_dirty_tracker_core: directed and random drawing commands
// depends on crfdt_pkg, crfdt_cmd_if / crfdt_res_if and the core; results checked in order
`timescale 1ns / 1ps

module tb_top;

  localparam int SCR_W = 240;
  localparam int SCR_H = 240;
  localparam int SCR_PIXELS = SCR_W * SCR_H;
  localparam int RANDOM_ITEMS = 113;
  localparam int IDLE_PCT = 15;
  localparam int REPORT_MAX = 10;
  // longest silent stretch is a screen fill or the clearing pass
  localparam int STALL_LIMIT = 250000;
  localparam int TAIL_CYCLES = 16;

  // command codes the block leaves unused
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] color;
  } cmd_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        region_valid;
    logic [7:0]  region_x;
    logic [7:0]  region_y;
    logic [7:0]  region_width;
    logic [7:0]  region_height;
  } result_t;

  logic clk_i;
  logic rst_ni;

  crfdt_cmd_if cmd_if ();
  crfdt_res_if res_if ();

  clipped_rect_fill_dirty_tracker_core #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // shadow framebuffer and dirty box
  logic [15:0] shadow_fb [SCR_PIXELS];
  bit          shadow_dirty;
  int          box_l, box_t, box_r, box_b;

  result_t pending_results[$];
  int      fail_cnt;
  int      silent_cycles;
  bit      steady_phase;
  int      hot_x[$];
  int      hot_y[$];

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // result sink stalls
  always @(posedge clk_i) begin
    res_if.ready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got_r = '{res_if.pixel_value, res_if.region_valid, res_if.region_x, res_if.region_y,
                res_if.region_width, res_if.region_height};
      if (pending_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX)
          $display("%0t: unexpected result pix=%h valid=%b x=%0d y=%0d w=%0d h=%0d",
                   $realtime, got_r.pixel_value, got_r.region_valid, got_r.region_x,
                   got_r.region_y, got_r.region_width, got_r.region_height);
      end else begin
        exp_r = pending_results.pop_front();
        if (got_r.pixel_value !== exp_r.pixel_value ||
            got_r.region_valid !== exp_r.region_valid ||
            got_r.region_x !== exp_r.region_x || got_r.region_y !== exp_r.region_y ||
            got_r.region_width !== exp_r.region_width ||
            got_r.region_height !== exp_r.region_height) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX)
            $display("%0t: mismatch exp pix=%h valid=%b x=%0d y=%0d w=%0d h=%0d",
                     $realtime, exp_r.pixel_value, exp_r.region_valid, exp_r.region_x,
                     exp_r.region_y, exp_r.region_width, exp_r.region_height,
                     " / got pix=%h valid=%b x=%0d y=%0d w=%0d h=%0d",
                     got_r.pixel_value, got_r.region_valid, got_r.region_x, got_r.region_y,
                     got_r.region_width, got_r.region_height);
        end
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
      silent_cycles = 0;
    else
      silent_cycles++;
    if (silent_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic bit on_screen(input int x, input int y);
    return x >= 0 && x < SCR_W && y >= 0 && y < SCR_H;
  endfunction

  // grow the dirty box by an on-screen rectangle, inclusive edges
  function automatic void grow_dirty_box(input int l, input int t, input int r, input int b);
    if (!shadow_dirty) begin
      box_l = l; box_t = t; box_r = r; box_b = b;
      shadow_dirty = 1'b1;
    end else begin
      if (l < box_l) box_l = l;
      if (t < box_t) box_t = t;
      if (r > box_r) box_r = r;
      if (b > box_b) box_b = b;
    end
    if (box_l < 0) box_l = 0;
    if (box_t < 0) box_t = 0;
    if (box_r > SCR_W - 1) box_r = SCR_W - 1;
    if (box_b > SCR_H - 1) box_b = SCR_H - 1;
  endfunction

  // apply one command to the shadow state and return the result it gives
  function automatic result_t frame_engine_result(input cmd_t c);
    result_t r;
    int x, y, w, h, lx, lw, row, col;
    r = '0;
    x = $signed(c.pos_x);
    y = $signed(c.pos_y);
    w = $signed(c.rect_width);
    h = $signed(c.rect_height);
    case (c.mode)
      crfdt_pkg::MODE_PIXEL: begin
        if (on_screen(x, y)) begin
          shadow_fb[y * SCR_W + x] = c.color;
          grow_dirty_box(x, y, x, y);
        end
      end
      crfdt_pkg::MODE_RECT: begin
        // clip in full precision
        if (x < 0) begin w += x; x = 0; end
        if (y < 0) begin h += y; y = 0; end
        if (x + w > SCR_W) w = SCR_W - x;
        if (y + h > SCR_H) h = SCR_H - y;
        if (w > 0 && h > 0) begin
          for (row = y; row < y + h; row++)
            for (col = x; col < x + w; col++)
              shadow_fb[row * SCR_W + col] = c.color;
          grow_dirty_box(x, y, x + w - 1, y + h - 1);
        end
      end
      crfdt_pkg::MODE_FILL: begin
        foreach (shadow_fb[i]) shadow_fb[i] = c.color;
        box_l = 0; box_t = 0; box_r = SCR_W - 1; box_b = SCR_H - 1;
        shadow_dirty = 1'b1;
      end
      crfdt_pkg::MODE_FLUSH: begin
        if (shadow_dirty) begin
          lx = box_l;
          lw = box_r - box_l + 1;
          // left edge aligned down to an even column
          if (lx[0]) begin lx -= 1; lw += 1; end
          r.region_valid = 1'b1;
          r.region_x = lx[7:0];
          r.region_y = box_t[7:0];
          r.region_width = lw[7:0];
          r.region_height = 8'(box_b - box_t + 1);
          shadow_dirty = 1'b0;
        end
      end
      crfdt_pkg::MODE_READ: begin
        if (on_screen(x, y)) r.pixel_value = shadow_fb[y * SCR_W + x];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_t mk_cmd(input logic [2:0] m, input int x, input int y,
                                  input int w, input int h, input logic [15:0] col);
    cmd_t c;
    c.mode = m;
    c.pos_x = x[15:0];
    c.pos_y = y[15:0];
    c.rect_width = w[15:0];
    c.rect_height = h[15:0];
    c.color = col;
    return c;
  endfunction

  // drive one command, wait for the transaction, then record its expected result
  task automatic issue_cmd(input cmd_t c);
    while (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.mode <= c.mode;
    cmd_if.pos_x <= c.pos_x;
    cmd_if.pos_y <= c.pos_y;
    cmd_if.rect_width <= c.rect_width;
    cmd_if.rect_height <= c.rect_height;
    cmd_if.color <= c.color;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    pending_results.push_back(frame_engine_result(c));
  endtask

  task automatic test_clean_state();
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FLUSH, 0, 0, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_READ, 0, 0, 0, 0, 16'h0));
    issue_cmd(mk_cmd(MODE_UNUSED_LO, 3, 4, 5, 6, 16'h1234));
    issue_cmd(mk_cmd(MODE_UNUSED_HI, 0, 0, 10, 10, 16'hFFFF));
  endtask

  task automatic test_pixel_plot();
    issue_cmd(mk_cmd(crfdt_pkg::MODE_PIXEL, 0, 0, 0, 0, 16'hFFFF));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, 16'h0001));
    // off screen plots write nothing
    issue_cmd(mk_cmd(crfdt_pkg::MODE_PIXEL, -1, 0, 0, 0, 16'hBEEF));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_PIXEL, SCR_W, 5, 0, 0, 16'hBEEF));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_PIXEL, 7, -32768, 0, 0, 16'hBEEF));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_READ, 0, 0, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_READ, SCR_W - 1, SCR_H - 1, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_READ, -32768, 5, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FLUSH, 0, 0, 0, 0, 16'h0));
    // odd column widens the flushed region to the left
    issue_cmd(mk_cmd(crfdt_pkg::MODE_PIXEL, 13, 7, 0, 0, 16'h5A5A));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FLUSH, 0, 0, 0, 0, 16'h0));
  endtask

  task automatic test_rect_clip();
    issue_cmd(mk_cmd(crfdt_pkg::MODE_RECT, 21, 30, 5, 4, 16'h8421));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_RECT, -5, -3, 10, 6, 16'h7BDE));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_RECT, SCR_W - 10, SCR_H - 4, 50, 50, 16'hF800));
    // empty after clipping
    issue_cmd(mk_cmd(crfdt_pkg::MODE_RECT, 10, 10, -4, 5, 16'h07E0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_RECT, -32768, 0, 32767, 5, 16'h07E0));
    // huge width clipped to the screen edge
    issue_cmd(mk_cmd(crfdt_pkg::MODE_RECT, -100, 100, 32767, 2, 16'h001F));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FLUSH, 0, 0, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_READ, 22, 31, 0, 0, 16'h0));
  endtask

  task automatic test_screen_fill();
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FILL, 0, 0, 0, 0, 16'hA5A5));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_READ, 120, 77, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FLUSH, 0, 0, 0, 0, 16'h0));
    issue_cmd(mk_cmd(crfdt_pkg::MODE_FLUSH, 0, 0, 0, 0, 16'h0));
  endtask

  // bursts of drawing with read-back of touched pixels and flushes, plus noise
  task automatic test_random_mix();
    cmd_t c;
    int pick, x, y, w, h, k;
    int big_left;
    int fills_left;
    big_left = 4;
    fills_left = 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_phase = (n >= 50 && n < 90);
      pick = $urandom_range(99);
      x = int'($urandom_range(SCR_W + 19)) - 10;
      y = int'($urandom_range(SCR_H + 19)) - 10;
      if (pick < 25) begin
        c = mk_cmd(crfdt_pkg::MODE_PIXEL, x, y, 0, 0, 16'($urandom_range(16'hFFFF)));
      end else if (pick < 50) begin
        if (big_left > 0 && $urandom_range(9) == 0) begin
          big_left--;
          c = mk_cmd(crfdt_pkg::MODE_RECT, $urandom(), $urandom(), $urandom(), $urandom(),
                     16'($urandom()));
        end else begin
          w = int'($urandom_range(48)) - 8;
          h = int'($urandom_range(48)) - 8;
          c = mk_cmd(crfdt_pkg::MODE_RECT, x - 10, y - 10, w, h,
                     16'($urandom_range(16'hFFFF)));
        end
      end else if (pick < 72) begin
        k = $urandom_range(9);
        if (k < 7 && hot_x.size() > 0) begin
          k = $urandom_range(hot_x.size() - 1);
          x = hot_x[k];
          y = hot_y[k];
        end else if (k == 9) begin
          x = $signed(16'($urandom()));
          y = $signed(16'($urandom()));
        end
        c = mk_cmd(crfdt_pkg::MODE_READ, x, y, $urandom(), $urandom(), 16'($urandom()));
      end else if (pick < 86) begin
        c = mk_cmd(crfdt_pkg::MODE_FLUSH, $urandom(), $urandom(), $urandom(), $urandom(),
                   16'($urandom()));
      end else if (pick < 89 && fills_left > 0) begin
        fills_left--;
        c = mk_cmd(crfdt_pkg::MODE_FILL, $urandom(), $urandom(), $urandom(), $urandom(),
                   16'($urandom()));
      end else if (pick < 94) begin
        c = mk_cmd(3'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO)), $urandom(), $urandom(),
                   $urandom(), $urandom(), 16'($urandom()));
      end else begin
        // full-range fields on the cheap commands
        case ($urandom_range(2))
          0: c = mk_cmd(crfdt_pkg::MODE_PIXEL, $urandom(), $urandom(), $urandom(), $urandom(),
                        16'($urandom()));
          1: c = mk_cmd(crfdt_pkg::MODE_READ, $urandom(), $urandom(), $urandom(), $urandom(),
                        16'($urandom()));
          default: c = mk_cmd(crfdt_pkg::MODE_FLUSH, $urandom(), $urandom(), $urandom(),
                              $urandom(), 16'($urandom()));
        endcase
      end
      issue_cmd(c);
      // remember touched pixels for later reads
      if (c.mode == crfdt_pkg::MODE_PIXEL || c.mode == crfdt_pkg::MODE_RECT) begin
        x = $signed(c.pos_x);
        y = $signed(c.pos_y);
        if (x < 0) x = 0;
        if (y < 0) y = 0;
        if (on_screen(x, y)) begin
          hot_x.push_back(x);
          hot_y.push_back(y);
          if (hot_x.size() > 16) begin
            void'(hot_x.pop_front());
            void'(hot_y.pop_front());
          end
        end
      end
    end
    steady_phase = 1'b0;
  endtask

  // sequence of tests
  initial begin
    steady_phase = 1'b0;
    shadow_dirty = 1'b0;
    box_l = 0; box_t = 0; box_r = 0; box_b = 0;
    foreach (shadow_fb[i]) shadow_fb[i] = 16'h0;
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.mode = crfdt_pkg::MODE_PIXEL;
    cmd_if.pos_x = '0;
    cmd_if.pos_y = '0;
    cmd_if.rect_width = '0;
    cmd_if.rect_height = '0;
    cmd_if.color = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_clean_state();
    test_pixel_plot();
    test_rect_clip();
    test_screen_fill();
    test_random_mix();

    // drain, then watch for stray results
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/crfdt_pkg.sv
rtl/crfdt_cmd_if.sv
rtl/crfdt_ctrl.sv
rtl/crfdt_datapath.sv
rtl/clipped_rect_fill_dirty_tracker_core.sv
test/tb_top.sv
